FILE: hdl/calendar_fields_to_seconds_assert.svh
// ----------------------------------------------------------------------------
// Calendar fields to seconds: assertion macros
// Concurrent checks clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_FIELDS_TO_SECONDS_ASSERT_SVH
`define CALENDAR_FIELDS_TO_SECONDS_ASSERT_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge
`define CFS_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("calendar_fields_to_seconds: check failed");
// cons must hold at the edge where ante holds
`define CFS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("calendar_fields_to_seconds: implication failed");
`else
`define CFS_ASSERT(label, expr)
`define CFS_ASSERT_IMPLY(label, ante, cons)
`endif

`endif

FILE: hdl/cfs_pkg.sv
// ----------------------------------------------------------------------------
// Calendar fields to seconds: package
// Field widths, pipeline payload types, leap rules and month tables.
// ----------------------------------------------------------------------------
`default_nettype none

package cfs_pkg;

  localparam int YEAR_W   = 17;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int FRAC_W   = 64;
  localparam int SECS_W   = 42;

  localparam int MAG_W    = 17;  // |year - 2000|, at most 67536
  localparam int QUOT_W   = 10;  // |year - 2000| / 100, at most 675
  localparam int N3_W     = 6;   // -year in the every-third-year band
  localparam int HMS_W    = 17;  // hour*3600 + minute*60 + second
  localparam int DCNT_W   = 25;  // magnitude of the year day count
  localparam int TDAY_W   = 27;  // signed day count
  localparam int DBM_W    = 9;   // days before month

  localparam logic signed [MAG_W:0]  EPOCH_YEAR = 18'sd2000;
  localparam logic [17:0]            RECIP_100  = 18'd167773;  // ceil(2^24 / 100)
  localparam int                     RECIP_SHIFT = 24;

  localparam logic signed [YEAR_W-1:0] YR_JULIAN_END   = 17'sd1752;
  localparam logic signed [YEAR_W-1:0] YR_JULIAN_START = 17'sd8;
  localparam logic signed [YEAR_W-1:0] YR_THIRD_START  = -17'sd45;
  localparam logic signed [YEAR_W-1:0] YR_THIRD_END    = -17'sd9;

  localparam logic [MONTH_W-1:0]  MONTH_FEB  = 4'd1;
  localparam logic [MONTH_W-1:0]  MONTH_MAR  = 4'd2;
  localparam logic [MONTH_W-1:0]  MONTH_DEC  = 4'd11;
  localparam logic [DAY_W-1:0]    LEAP_DAY   = 5'd28;
  localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
  localparam logic [MINUTE_W-1:0] MINSEC_MAX = 6'd59;

  localparam logic signed [SECS_W-1:0] SECS_PER_DAY = 42'sd86400;

  typedef enum logic [1:0] {
    RULE_NONE,
    RULE_GREGORIAN,
    RULE_JULIAN,
    RULE_THIRD
  } leap_rule_t;

  typedef struct packed {
    logic                neg;
    logic [MAG_W-1:0]    mag;
    leap_rule_t          rule;
    logic [N3_W-1:0]     n3;
    logic [QUOT_W-1:0]   q100;
    logic                third_leap;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic                month_bad;
    logic                time_bad;
    logic [HMS_W-1:0]    hms;
    logic [FRAC_W-1:0]   frac;
  } dec_t;

  typedef struct packed {
    logic                neg;
    logic [MAG_W-1:0]    mag;
    logic [DCNT_W-1:0]   dcnt;
    logic                leap;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic                month_bad;
    logic                time_bad;
    logic [HMS_W-1:0]    hms;
    logic [FRAC_W-1:0]   frac;
  } cnt_t;

  typedef struct packed {
    logic signed [TDAY_W-1:0] tday;
    logic                     fail;
    logic [HMS_W-1:0]         hms;
    logic [FRAC_W-1:0]        frac;
  } day_t;

  typedef struct packed {
    logic signed [SECS_W-1:0] prod;
    logic                     fail;
    logic [HMS_W-1:0]         hms;
    logic [FRAC_W-1:0]        frac;
  } sec_t;

  function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] month);
    logic [DBM_W-1:0] d;
    case (month)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // zero-based last day; February is given with its leap day
  function automatic logic [DAY_W-1:0] last_day(input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] d;
    case (month)
      4'd1:                      d = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd29;
      default:                   d = 5'd30;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/cfs_if.sv
// ----------------------------------------------------------------------------
// Calendar fields to seconds: channel interfaces
// Valid/ready channels for the date items in and the second counts out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfs_date_if;
  logic                                valid;
  logic                                ready;
  logic signed [cfs_pkg::YEAR_W-1:0]   year_number;
  logic [cfs_pkg::MONTH_W-1:0]         month_index;
  logic [cfs_pkg::DAY_W-1:0]           day_index;
  logic [cfs_pkg::HOUR_W-1:0]          hour_value;
  logic [cfs_pkg::MINUTE_W-1:0]        minute_value;
  logic [cfs_pkg::SECOND_W-1:0]        second_value;
  logic [cfs_pkg::FRAC_W-1:0]          fraction_in;

  modport source (
    output valid, year_number, month_index, day_index, hour_value,
           minute_value, second_value, fraction_in,
    input  ready
  );
  modport sink (
    input  valid, year_number, month_index, day_index, hour_value,
           minute_value, second_value, fraction_in,
    output ready
  );
endinterface

interface cfs_secs_if;
  logic                                valid;
  logic                                ready;
  logic signed [cfs_pkg::SECS_W-1:0]   whole_seconds;
  logic [cfs_pkg::FRAC_W-1:0]          fraction_out;
  logic                                status;

  modport source (output valid, whole_seconds, fraction_out, status, input ready);
  modport sink   (input valid, whole_seconds, fraction_out, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/cfs_decode.sv
// ----------------------------------------------------------------------------
// Calendar fields to seconds: decode stages
// Year offset magnitude, leap rule, field checks, then quotient by 100 and
// the every-third-year test by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_decode (
  input  logic          clk,
  input  logic          rst,
  cfs_date_if.sink      date_in,
  output logic          out_valid,
  input  logic          out_ready,
  output cfs_pkg::dec_t out_data
);

  localparam int                    P100_W   = cfs_pkg::MAG_W + 18;
  localparam int                    P3_W     = 2 * cfs_pkg::N3_W;
  localparam logic [P3_W-1:0]       RECIP_3  = 12'd43;   // ceil(2^7 / 3)
  localparam int                    R3_SHIFT = 7;

  logic          v1;
  logic          v2;
  logic          rdy1;
  logic          rdy2;
  cfs_pkg::dec_t s1;
  cfs_pkg::dec_t s1_next;
  cfs_pkg::dec_t s2;
  cfs_pkg::dec_t s2_next;

  logic signed [cfs_pkg::MAG_W:0] off;
  logic [P100_W-1:0]              p100;
  logic [P3_W-1:0]                p3;
  logic [cfs_pkg::N3_W-1:0]       q3;
  logic [cfs_pkg::N3_W-1:0]       rem3;

  assign rdy2          = !v2 || out_ready;
  assign rdy1          = !v1 || rdy2;
  assign date_in.ready = rdy1;
  assign out_valid     = v2;
  assign out_data      = s2;

  assign off = (cfs_pkg::MAG_W+1)'(date_in.year_number) - cfs_pkg::EPOCH_YEAR;

  always_comb begin
    s1_next            = '0;
    s1_next.neg        = off[cfs_pkg::MAG_W];
    s1_next.mag        = off[cfs_pkg::MAG_W] ? cfs_pkg::MAG_W'(-off)
                                             : cfs_pkg::MAG_W'(off);
    if (date_in.year_number > cfs_pkg::YR_JULIAN_END) begin
      s1_next.rule = cfs_pkg::RULE_GREGORIAN;
    end else if (date_in.year_number >= cfs_pkg::YR_JULIAN_START) begin
      s1_next.rule = cfs_pkg::RULE_JULIAN;
    end else if (date_in.year_number >= cfs_pkg::YR_THIRD_START &&
                 date_in.year_number <= cfs_pkg::YR_THIRD_END) begin
      s1_next.rule = cfs_pkg::RULE_THIRD;
    end else begin
      s1_next.rule = cfs_pkg::RULE_NONE;
    end
    s1_next.n3         = cfs_pkg::N3_W'(-date_in.year_number);
    s1_next.month      = date_in.month_index;
    s1_next.day        = date_in.day_index;
    s1_next.month_bad  = date_in.month_index > cfs_pkg::MONTH_DEC;
    s1_next.time_bad   = (date_in.hour_value > cfs_pkg::HOUR_MAX) ||
                         (date_in.minute_value > cfs_pkg::MINSEC_MAX) ||
                         (date_in.second_value > cfs_pkg::MINSEC_MAX);
    s1_next.hms        = cfs_pkg::HMS_W'(date_in.hour_value) * 17'd3600 +
                         cfs_pkg::HMS_W'(date_in.minute_value) * 17'd60 +
                         cfs_pkg::HMS_W'(date_in.second_value);
    s1_next.frac       = date_in.fraction_in;
  end

  // exact for every 17-bit magnitude: the reciprocal error stays below 2^7
  assign p100 = P100_W'(s1.mag) * P100_W'(cfs_pkg::RECIP_100);
  assign p3   = P3_W'(s1.n3) * RECIP_3;
  assign q3   = cfs_pkg::N3_W'(p3 >> R3_SHIFT);
  assign rem3 = s1.n3 - cfs_pkg::N3_W'(q3 * 6'd3);

  always_comb begin
    s2_next            = s1;
    s2_next.q100       = p100[cfs_pkg::RECIP_SHIFT +: cfs_pkg::QUOT_W];
    s2_next.third_leap = (rem3 == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= date_in.valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && date_in.valid) s1 <= s1_next;
    if (rdy2 && v1) s2 <= s2_next;
  end

endmodule

`default_nettype wire

FILE: hdl/cfs_day_count.sv
// ----------------------------------------------------------------------------
// Calendar fields to seconds: day count stages
// Year day count and leap decision, then the signed day number with month,
// day and leap corrections, and the pass/fail decision.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_day_count (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfs_pkg::dec_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cfs_pkg::day_t out_data
);

  localparam int TW = cfs_pkg::TDAY_W;

  logic          v3;
  logic          v4;
  logic          rdy3;
  logic          rdy4;
  cfs_pkg::cnt_t s3;
  cfs_pkg::cnt_t s3_next;
  cfs_pkg::day_t s4;
  cfs_pkg::day_t s4_next;

  logic a4z;
  logic a100z;
  logic a400z;
  logic leap;

  logic signed [TW-1:0] tmag;
  logic signed [TW-1:0] t0;
  logic signed [TW-1:0] offs;
  logic signed [TW-1:0] tday;
  logic                 adj;
  logic                 day_bad;
  logic                 sign_bad;

  assign rdy4      = !v4 || out_ready;
  assign rdy3      = !v3 || rdy4;
  assign in_ready  = rdy3;
  assign out_valid = v4;
  assign out_data  = s4;

  // divisibility of |year - 2000| matches that of the year itself
  assign a4z   = (in_data.mag[1:0] == 2'd0);
  assign a100z = (in_data.mag == cfs_pkg::MAG_W'(in_data.q100) * 17'd100);
  assign a400z = a100z && (in_data.q100[1:0] == 2'd0);

  always_comb begin
    case (in_data.rule)
      cfs_pkg::RULE_GREGORIAN: leap = a4z && (!a100z || a400z);
      cfs_pkg::RULE_JULIAN:    leap = a4z;
      cfs_pkg::RULE_THIRD:     leap = in_data.third_leap;
      default:                 leap = 1'b0;
    endcase
  end

  always_comb begin
    s3_next.neg       = in_data.neg;
    s3_next.mag       = in_data.mag;
    s3_next.dcnt      = cfs_pkg::DCNT_W'(in_data.mag) * 25'd365 +
                        cfs_pkg::DCNT_W'(in_data.mag >> 2) -
                        cfs_pkg::DCNT_W'(in_data.q100) +
                        cfs_pkg::DCNT_W'(in_data.q100 >> 2);
    s3_next.leap      = leap;
    s3_next.month     = in_data.month;
    s3_next.day       = in_data.day;
    s3_next.month_bad = in_data.month_bad;
    s3_next.time_bad  = in_data.time_bad;
    s3_next.hms       = in_data.hms;
    s3_next.frac      = in_data.frac;
  end

  always_comb begin
    tmag = signed'(TW'(s3.dcnt));
    t0   = s3.neg ? -tmag : tmag;
    offs = s3.neg ? -signed'(TW'(s3.mag)) : signed'(TW'(s3.mag));
    // from 2000 on one day is added except before March of a leap year; earlier
    // years add the leap day once past February
    if (!s3.neg) begin
      adj = !((s3.month < cfs_pkg::MONTH_MAR) && s3.leap);
    end else begin
      adj = (s3.month >= cfs_pkg::MONTH_MAR) && s3.leap;
    end
    tday = t0 + signed'(TW'(adj)) +
           signed'(TW'(cfs_pkg::days_before(s3.month))) +
           signed'(TW'(s3.day));
    day_bad  = (s3.day > cfs_pkg::last_day(s3.month)) ||
               ((s3.month == cfs_pkg::MONTH_FEB) && (s3.day == cfs_pkg::LEAP_DAY) &&
                !s3.leap);
    sign_bad = s3.neg ? (tday > offs) : (tday < offs);
    s4_next.tday = tday;
    s4_next.fail = s3.month_bad || day_bad || sign_bad || s3.time_bad;
    s4_next.hms  = s3.hms;
    s4_next.frac = s3.frac;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy3) v3 <= in_valid;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) s3 <= s3_next;
    if (rdy4 && v3) s4 <= s4_next;
  end

endmodule

`default_nettype wire

FILE: hdl/cfs_time_scale.sv
// ----------------------------------------------------------------------------
// Calendar fields to seconds: seconds stages
// Day number times 86400, then time of day added, fraction negated for
// negative results and failed items zeroed into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfs_time_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfs_pkg::day_t in_data,
  cfs_secs_if.source    secs_out
);

  localparam int SW = cfs_pkg::SECS_W;

  logic          v5;
  logic          v6;
  logic          rdy5;
  logic          rdy6;
  cfs_pkg::sec_t s5;
  cfs_pkg::sec_t s5_next;

  logic signed [SW-1:0]          secs;
  logic signed [SW-1:0]          result_secs;
  logic signed [SW-1:0]          result_secs_next;
  logic [cfs_pkg::FRAC_W-1:0]    result_frac;
  logic [cfs_pkg::FRAC_W-1:0]    result_frac_next;
  logic                          result_status;

  assign rdy6     = !v6 || secs_out.ready;
  assign rdy5     = !v5 || rdy6;
  assign in_ready = rdy5;

  assign secs_out.valid         = v6;
  assign secs_out.whole_seconds = result_secs;
  assign secs_out.fraction_out  = result_frac;
  assign secs_out.status        = result_status;

  always_comb begin
    s5_next.prod = SW'(in_data.tday) * cfs_pkg::SECS_PER_DAY;
    s5_next.fail = in_data.fail;
    s5_next.hms  = in_data.hms;
    s5_next.frac = in_data.frac;
  end

  assign secs = s5.prod + signed'(SW'(s5.hms));

  always_comb begin
    if (s5.fail) begin
      result_secs_next = '0;
      result_frac_next = '0;
    end else begin
      result_secs_next = secs;
      result_frac_next = secs[SW-1] ? (cfs_pkg::FRAC_W'(0) - s5.frac) : s5.frac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy5) v5 <= in_valid;
      if (rdy6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && in_valid) s5 <= s5_next;
    if (rdy6 && v5) begin
      result_secs   <= result_secs_next;
      result_frac   <= result_frac_next;
      result_status <= s5.fail;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/calendar_fields_to_seconds.sv
// ----------------------------------------------------------------------------
// Calendar fields to seconds
// Broken-down date and time to signed seconds from 2000-01-01 00:00:00.
//
//   channel    dir  protocol     payload
//   date_in    in   valid/ready  year, month, day, hour, minute, second, fraction
//   secs_out   out  valid/ready  whole_seconds, fraction_out, status
//
// One item per cycle unless secs_out stalls; each item passes the decode, day count and seconds stage registers.
// The depth is set by the reciprocal multiply for the year quotients and the
// day-to-seconds multiply, each with a register stage of its own.
// rst clears the stage valid bits only.
// Each stage holds while the next one is full and stalled; empty stages fill,
// so date_in stays ready until every stage holds an item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calendar_fields_to_seconds_assert.svh"

module calendar_fields_to_seconds (
  input  logic        clk,
  input  logic        rst,
  cfs_date_if.sink    date_in,
  cfs_secs_if.source  secs_out
);

  logic          dec_valid;
  logic          dec_ready;
  cfs_pkg::dec_t dec_data;
  logic          day_valid;
  logic          day_ready;
  cfs_pkg::day_t day_data;

  cfs_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .date_in   (date_in),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  cfs_day_count u_day_count (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (day_valid),
    .out_ready (day_ready),
    .out_data  (day_data)
  );

  cfs_time_scale u_time_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (day_valid),
    .in_ready (day_ready),
    .in_data  (day_data),
    .secs_out (secs_out)
  );

  // a failed item carries no seconds and no fraction
  `CFS_ASSERT_IMPLY(a_fail_zero, secs_out.valid && secs_out.status, secs_out.whole_seconds == '0 && secs_out.fraction_out == '0)

  // back-pressure reaches the input only when the pipe is full
  `CFS_ASSERT(a_stall_full, date_in.ready || (dec_valid && day_valid && secs_out.valid))

endmodule

`default_nettype wire
